### design/zlx_pkg.sv
// Shared constants and types for the zero-lag cross-correlation accumulator.
// No dependencies; every other design file uses this package.
`default_nettype none

package zlx_pkg;

  // Default sizes of the top level
  localparam int NUM_POINTS_DEF  = 4096;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ACC_BITS_DEF    = 48;

  // Fixed field widths
  localparam int POINT_W     = 12;
  localparam int OP_W        = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ACCUMULATE = 2'd0;
  localparam logic [OP_W-1:0] OP_START      = 2'd1;
  localparam logic [OP_W-1:0] OP_READ       = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_VP         = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_VS         = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_DENSITY    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_POROSITY   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_SATURATION = 3'd4;

  // Wavefield sample slots
  localparam int NUM_WAVE = 5;
  localparam int W_XX     = 0;
  localparam int W_YY     = 1;
  localparam int W_XY     = 2;
  localparam int W_VX     = 3;
  localparam int W_VY     = 4;

  // Accumulator slots
  localparam int NUM_ACC  = 5;
  localparam int A_LAMBDA = 0;
  localparam int A_MU_A   = 1;
  localparam int A_MU_B   = 2;
  localparam int A_MU_C   = 3;
  localparam int A_RHO    = 4;

  // Writes in flight that a read of the store can miss
  localparam int FWD_DEPTH = 3;

  typedef struct packed {
    logic lambda_en;
    logic mu_en;
    logic rho_en;
  } acc_enable_t;

endpackage

`default_nettype wire

### design/zlx_item_if.sv
// Input channel: one grid point with forward and adjoint wavefield samples.
// Depends on zlx_pkg.
`default_nettype none

interface zlx_item_if #(
  parameter int SAMPLE_BITS = zlx_pkg::SAMPLE_BITS_DEF
);
  import zlx_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [OP_W-1:0]               op;
  logic [POINT_W-1:0]            point;
  logic signed [SAMPLE_BITS-1:0] fwd_sxx;
  logic signed [SAMPLE_BITS-1:0] fwd_syy;
  logic signed [SAMPLE_BITS-1:0] fwd_sxy;
  logic signed [SAMPLE_BITS-1:0] fwd_vx;
  logic signed [SAMPLE_BITS-1:0] fwd_vy;
  logic signed [SAMPLE_BITS-1:0] adj_sxx;
  logic signed [SAMPLE_BITS-1:0] adj_syy;
  logic signed [SAMPLE_BITS-1:0] adj_sxy;
  logic signed [SAMPLE_BITS-1:0] adj_vx;
  logic signed [SAMPLE_BITS-1:0] adj_vy;

  modport source (
    output valid, op, point, fwd_sxx, fwd_syy, fwd_sxy, fwd_vx, fwd_vy,
           adj_sxx, adj_syy, adj_sxy, adj_vx, adj_vy,
    input  ready
  );

  modport sink (
    input  valid, op, point, fwd_sxx, fwd_syy, fwd_sxy, fwd_vx, fwd_vy,
           adj_sxx, adj_syy, adj_sxy, adj_vx, adj_vy,
    output ready
  );

endinterface

`default_nettype wire

### design/zlx_result_if.sv
// Result channel: the five accumulator values of a point and the clip flag.
// Depends on zlx_pkg.
`default_nettype none

interface zlx_result_if #(
  parameter int ACC_BITS = zlx_pkg::ACC_BITS_DEF
);

  logic                       valid;
  logic                       ready;
  logic signed [ACC_BITS-1:0] lambda_sum;
  logic signed [ACC_BITS-1:0] mu_a_sum;
  logic signed [ACC_BITS-1:0] mu_b_sum;
  logic signed [ACC_BITS-1:0] mu_c_sum;
  logic signed [ACC_BITS-1:0] rho_sum;
  logic                       saturated;

  modport source (
    output valid, lambda_sum, mu_a_sum, mu_b_sum, mu_c_sum, rho_sum, saturated,
    input  ready
  );

  modport sink (
    input  valid, lambda_sum, mu_a_sum, mu_b_sum, mu_c_sum, rho_sum, saturated,
    output ready
  );

endinterface

`default_nettype wire

### design/zero_lag_xcorr_accumulate_2d.sv
// Zero-lag cross-correlation accumulator: five saturating sums per grid point.
// Throughput one transaction per cycle while the output is not stalled; each
// result passes the store read, two product stages and a saturating add.
// The point store is one synchronous memory read and written once per advance.
// Reset (rst, synchronous) clears the flags, pipeline and output valid; store
// contents are undefined until a start transaction writes the point.
`default_nettype none

module zero_lag_xcorr_accumulate_2d #(
  parameter int NUM_POINTS  = zlx_pkg::NUM_POINTS_DEF,
  parameter int SAMPLE_BITS = zlx_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = zlx_pkg::ACC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  zlx_item_if.sink                         item,
  zlx_result_if.source                     result,
  input  logic                             cfg_we,
  input  logic [zlx_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [zlx_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import zlx_pkg::*;

  localparam int ADDR_W   = $clog2(NUM_POINTS);
  localparam int PT_EXT_W = (ADDR_W > POINT_W) ? ADDR_W : POINT_W;
  localparam int INC_W    = 2 * SAMPLE_BITS + 2;
  localparam int SUM_W    = ((ACC_BITS > INC_W) ? ACC_BITS : INC_W) + 1;
  localparam int HI_W     = SUM_W - ACC_BITS + 1;
  localparam int ENTRY_W  = NUM_ACC * ACC_BITS;

  typedef logic [NUM_ACC-1:0][ACC_BITS-1:0] entry_t;

  typedef struct packed {
    logic              valid;
    logic              update;    // accumulate or start: the entry is written
    logic              fresh;     // start: stored values count as zero
    logic              in_range;
    logic [ADDR_W-1:0] addr;
  } ctl_t;

  // ---------------------------------------------------------------------------
  // Configuration flags and accumulator group enables
  // ---------------------------------------------------------------------------
  logic        invert_vp;
  logic        invert_vs;
  logic        invert_density;
  logic        invert_porosity;
  logic        invert_saturation;
  acc_enable_t grp_en;
  logic [NUM_ACC-1:0] acc_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      invert_vp         <= 1'b0;
      invert_vs         <= 1'b0;
      invert_density    <= 1'b0;
      invert_porosity   <= 1'b0;
      invert_saturation <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INVERT_VP:         invert_vp         <= cfg_data;
        REG_INVERT_VS:         invert_vs         <= cfg_data;
        REG_INVERT_DENSITY:    invert_density    <= cfg_data;
        REG_INVERT_POROSITY:   invert_porosity   <= cfg_data;
        REG_INVERT_SATURATION: invert_saturation <= cfg_data;
        default: ;
      endcase
    end
  end

  // Density, porosity and saturation enable everything; S velocity adds the
  // mu terms and lambda; P velocity enables lambda alone.
  always_comb begin
    grp_en.rho_en    = invert_density | invert_porosity | invert_saturation;
    grp_en.mu_en     = grp_en.rho_en | invert_vs;
    grp_en.lambda_en = grp_en.mu_en | invert_vp;
    acc_en[A_LAMBDA] = grp_en.lambda_en;
    acc_en[A_MU_A]   = grp_en.mu_en;
    acc_en[A_MU_B]   = grp_en.mu_en;
    acc_en[A_MU_C]   = grp_en.mu_en;
    acc_en[A_RHO]    = grp_en.rho_en;
  end

  // ---------------------------------------------------------------------------
  // Handshake: the whole pipeline moves together whenever the output register
  // is empty or being drained, so a held result stalls every stage.
  // ---------------------------------------------------------------------------
  logic advance;
  logic accept;

  assign advance    = !result.valid || result.ready;
  assign item.ready = !rst && advance;
  assign accept     = item.valid && item.ready;

  // ---------------------------------------------------------------------------
  // Stage one: decode the transaction, latch samples, issue the store read
  // ---------------------------------------------------------------------------
  logic [PT_EXT_W-1:0]                      pt_ext;
  ctl_t                                     ctl_in;
  ctl_t                                     s1;
  ctl_t                                     s2;
  ctl_t                                     s3;
  logic [NUM_WAVE-1:0][SAMPLE_BITS-1:0]     s1_fwd;
  logic [NUM_WAVE-1:0][SAMPLE_BITS-1:0]     s1_adj;

  assign pt_ext = PT_EXT_W'(item.point);

  always_comb begin
    ctl_in.valid    = accept;
    ctl_in.update   = (item.op == OP_ACCUMULATE) || (item.op == OP_START);
    ctl_in.fresh    = (item.op == OP_START);
    ctl_in.in_range = (32'(item.point) < 32'(NUM_POINTS));
    ctl_in.addr     = pt_ext[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
      s3 <= '0;
    end else if (advance) begin
      s1 <= ctl_in;
      s2 <= s1;
      s3 <= s2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_fwd[W_XX] <= item.fwd_sxx;
      s1_fwd[W_YY] <= item.fwd_syy;
      s1_fwd[W_XY] <= item.fwd_sxy;
      s1_fwd[W_VX] <= item.fwd_vx;
      s1_fwd[W_VY] <= item.fwd_vy;
      s1_adj[W_XX] <= item.adj_sxx;
      s1_adj[W_YY] <= item.adj_syy;
      s1_adj[W_XY] <= item.adj_sxy;
      s1_adj[W_VX] <= item.adj_vx;
      s1_adj[W_VY] <= item.adj_vy;
    end
  end

  // ---------------------------------------------------------------------------
  // Point store: one entry holds all five accumulators. Read and write share
  // the advance strobe; a read at the edge of a write returns the old entry.
  // ---------------------------------------------------------------------------
  logic [ENTRY_W-1:0] store_mem [NUM_POINTS];
  logic [ENTRY_W-1:0] rd_data;
  logic               wr_en;
  entry_t             wr_data;

  always_ff @(posedge clk) begin
    if (advance) begin
      rd_data <= store_mem[ctl_in.addr];
    end
    if (wr_en) begin
      store_mem[s3.addr] <= wr_data;
    end
  end

  // Carry the stored entry alongside the products
  entry_t s2_old;
  entry_t s3_old;

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_old <= rd_data;
      s3_old <= s2_old;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages two and three: products, then increments
  // ---------------------------------------------------------------------------
  logic [NUM_ACC-1:0][INC_W-1:0] inc;

  zlx_prod #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_prod (
    .clk     (clk),
    .advance (advance),
    .fwd     (s1_fwd),
    .adj     (s1_adj),
    .inc     (inc)
  );

  // ---------------------------------------------------------------------------
  // Forwarding: the read of a transaction misses the writes of the three
  // transactions ahead of it. Keep those writes and take the newest match.
  // ---------------------------------------------------------------------------
  logic [FWD_DEPTH-1:0]  hist_valid;
  logic [ADDR_W-1:0]     hist_addr [FWD_DEPTH];
  entry_t                hist_data [FWD_DEPTH];
  entry_t                cur_old;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= '0;
    end else if (advance) begin
      hist_valid <= {hist_valid[FWD_DEPTH-2:0], wr_en};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hist_addr[0] <= s3.addr;
      hist_data[0] <= wr_data;
      for (int i = 1; i < FWD_DEPTH; i++) begin
        hist_addr[i] <= hist_addr[i-1];
        hist_data[i] <= hist_data[i-1];
      end
    end
  end

  always_comb begin
    cur_old = s3_old;
    // Oldest first so the most recent write wins
    for (int i = FWD_DEPTH - 1; i >= 0; i--) begin
      if (hist_valid[i] && (hist_addr[i] == s3.addr)) begin
        cur_old = hist_data[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Saturating add and result selection
  // ---------------------------------------------------------------------------
  entry_t out_val;
  logic   out_clip;

  always_comb begin
    logic [ACC_BITS-1:0] prev;
    logic [SUM_W-1:0]    sum;
    logic [HI_W-1:0]     hi;
    logic                ovf;
    logic [ACC_BITS-1:0] sat_val;

    out_clip = 1'b0;
    wr_data  = cur_old;
    out_val  = '0;
    for (int k = 0; k < NUM_ACC; k++) begin
      prev = s3.fresh ? '0 : cur_old[k];
      sum  = SUM_W'($signed(prev)) + SUM_W'($signed(inc[k]));
      // Clip when the bits above the accumulator's sign disagree with it
      hi   = sum[SUM_W-1:ACC_BITS-1];
      ovf  = !((&hi) || !(|hi));
      if (ovf) begin
        sat_val = sum[SUM_W-1] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                               : {1'b0, {(ACC_BITS-1){1'b1}}};
      end else begin
        sat_val = sum[ACC_BITS-1:0];
      end

      if (s3.update) begin
        // Disabled accumulators keep their value, or drop to zero on start
        wr_data[k] = acc_en[k] ? sat_val : prev;
        out_val[k] = acc_en[k] ? sat_val : '0;
        out_clip   = out_clip | (acc_en[k] & ovf);
      end else begin
        out_val[k] = acc_en[k] ? cur_old[k] : '0;
      end
    end

    // Out-of-range points report all zero and leave the store alone
    if (!s3.in_range) begin
      out_val  = '0;
      out_clip = 1'b0;
    end
  end

  assign wr_en = advance && s3.valid && s3.update && s3.in_range;

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= s3.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.lambda_sum <= out_val[A_LAMBDA];
      result.mu_a_sum   <= out_val[A_MU_A];
      result.mu_b_sum   <= out_val[A_MU_B];
      result.mu_c_sum   <= out_val[A_MU_C];
      result.rho_sum    <= out_val[A_RHO];
      result.saturated  <= out_clip;
    end
  end

endmodule

`default_nettype wire

### design/zlx_prod.sv
// Two-stage product pipeline: forms the exact increment of each accumulator.
// Depends on zlx_pkg; instantiated by zero_lag_xcorr_accumulate_2d.
`default_nettype none

module zlx_prod #(
  parameter int SAMPLE_BITS = zlx_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              advance,
  input  logic [zlx_pkg::NUM_WAVE-1:0][SAMPLE_BITS-1:0]     fwd,
  input  logic [zlx_pkg::NUM_WAVE-1:0][SAMPLE_BITS-1:0]     adj,
  output logic [zlx_pkg::NUM_ACC-1:0][2*SAMPLE_BITS+1:0]    inc
);
  import zlx_pkg::*;

  localparam int PW    = 2 * SAMPLE_BITS;
  localparam int INC_W = 2 * SAMPLE_BITS + 2;

  logic signed [SAMPLE_BITS:0]  fwd_sum;
  logic signed [SAMPLE_BITS:0]  adj_sum;
  logic signed [INC_W-1:0]      p_lam;
  logic signed [PW-1:0]         p_xx;
  logic signed [PW-1:0]         p_yy;
  logic signed [PW-1:0]         p_yx;
  logic signed [PW-1:0]         p_xy;
  logic signed [PW-1:0]         p_shear;
  logic signed [PW-1:0]         p_vx;
  logic signed [PW-1:0]         p_vy;

  // Normal stress sums kept exact, one bit wider than a sample
  assign fwd_sum = $signed(fwd[W_XX]) + $signed(fwd[W_YY]);
  assign adj_sum = $signed(adj[W_XX]) + $signed(adj[W_YY]);

  // Stage one: one multiplier per product, registered
  always_ff @(posedge clk) begin
    if (advance) begin
      p_lam   <= fwd_sum * adj_sum;
      p_xx    <= $signed(fwd[W_XX]) * $signed(adj[W_XX]);
      p_yy    <= $signed(fwd[W_YY]) * $signed(adj[W_YY]);
      p_yx    <= $signed(fwd[W_YY]) * $signed(adj[W_XX]);
      p_xy    <= $signed(fwd[W_XX]) * $signed(adj[W_YY]);
      p_shear <= $signed(fwd[W_XY]) * $signed(adj[W_XY]);
      p_vx    <= $signed(fwd[W_VX]) * $signed(adj[W_VX]);
      p_vy    <= $signed(fwd[W_VY]) * $signed(adj[W_VY]);
    end
  end

  // Stage two: pair up the products into increments
  always_ff @(posedge clk) begin
    if (advance) begin
      inc[A_LAMBDA] <= p_lam;
      inc[A_MU_A]   <= INC_W'(p_xx) + INC_W'(p_yy);
      inc[A_MU_B]   <= INC_W'(p_yx) + INC_W'(p_xy);
      inc[A_MU_C]   <= INC_W'(p_shear);
      inc[A_RHO]    <= INC_W'(p_vx) + INC_W'(p_vy);
    end
  end

endmodule

`default_nettype wire

### design/zlx_checker.sv
// Port-level checks for zero_lag_xcorr_accumulate_2d, attached by bind.
// Depends on zlx_pkg for default sizes.
`default_nettype none

module zlx_checker #(
  parameter int ACC_BITS = zlx_pkg::ACC_BITS_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [ACC_BITS-1:0] lambda_sum,
  input logic                saturated
);

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A held result stalls the input side
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while result stalled");

  // An empty output register never holds off the input side
  a_empty_takes_input: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A stalled result stays offered
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its lambda sum and clip flag
  a_payload_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(lambda_sum) && $stable(saturated)))
    else $error("result payload changed while stalled");

endmodule

bind zero_lag_xcorr_accumulate_2d zlx_checker #(
  .ACC_BITS (ACC_BITS)
) u_zlx_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (item.valid),
  .in_ready   (item.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .lambda_sum (result.lambda_sum),
  .saturated  (result.saturated)
);

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for zero_lag_xcorr_accumulate_2d: random and directed
// transactions with an in-bench accumulator predictor and scoreboard.
// Depends on zlx_pkg, zlx_item_if, zlx_result_if and the block itself.
`default_nettype none

module tb_top;
  import zlx_pkg::*;

  localparam int NPTS = NUM_POINTS_DEF;
  localparam int SW = SAMPLE_BITS_DEF;
  localparam int ACC_W = ACC_BITS_DEF;

  // Op code 3 is unused by the block; it behaves as a read
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  // Bit k of a flag set goes to register FLAG_REGS[k]
  localparam logic [CFG_INDEX_W-1:0] FLAG_REGS [5] = '{REG_INVERT_VP, REG_INVERT_VS,
    REG_INVERT_DENSITY, REG_INVERT_POROSITY, REG_INVERT_SATURATION};

  // Flag sets of the random phases; the last one is replaced by a random set
  localparam bit [4:0] PHASE_FLAGS [9] = '{5'b00000, 5'b00001, 5'b00010, 5'b00100,
    5'b01000, 5'b10000, 5'b11111, 5'b00011, 5'b00000};

  localparam int PHASE_ITEMS = 150;
  localparam int HOLD_CYCLES = 250;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [POINT_W-1:0]   point;
    logic signed [SW-1:0] fwd_sxx;
    logic signed [SW-1:0] fwd_syy;
    logic signed [SW-1:0] fwd_sxy;
    logic signed [SW-1:0] fwd_vx;
    logic signed [SW-1:0] fwd_vy;
    logic signed [SW-1:0] adj_sxx;
    logic signed [SW-1:0] adj_syy;
    logic signed [SW-1:0] adj_sxy;
    logic signed [SW-1:0] adj_vx;
    logic signed [SW-1:0] adj_vy;
  } grid_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] lambda_sum;
    logic signed [ACC_W-1:0] mu_a_sum;
    logic signed [ACC_W-1:0] mu_b_sum;
    logic signed [ACC_W-1:0] mu_c_sum;
    logic signed [ACC_W-1:0] rho_sum;
    logic                    saturated;
  } point_sums_t;

  // Imaging-condition predictor: keeps its own copy of the five stores and the
  // inversion flags, and queues the sums each accepted transaction should give.
  class xcorr_scoreboard;
    bit flag_vp, flag_vs, flag_density, flag_porosity, flag_saturation;
    longint point_acc [NUM_ACC][NPTS];
    point_sums_t expected_sums[$];
    bit clipped;
    int mismatches;

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_INVERT_VP:         flag_vp = val[0];
        REG_INVERT_VS:         flag_vs = val[0];
        REG_INVERT_DENSITY:    flag_density = val[0];
        REG_INVERT_POROSITY:   flag_porosity = val[0];
        REG_INVERT_SATURATION: flag_saturation = val[0];
        default: ;
      endcase
    endfunction

    function longint clip_add(longint base, longint delta);
      longint hi, lo, sum;
      hi = (longint'(1) <<< (ACC_W - 1)) - 1;
      lo = -hi - 1;
      sum = base + delta;
      if (sum > hi) begin
        clipped = 1'b1;
        return hi;
      end
      if (sum < lo) begin
        clipped = 1'b1;
        return lo;
      end
      return sum;
    endfunction

    function void note_item(grid_item_t it);
      bit en [NUM_ACC];
      longint delta [NUM_ACC];
      longint sums [NUM_ACC];
      longint fxx, fyy, fxy, fvx, fvy, axx, ayy, axy, avx, avy;
      bit rho_on, mu_on, fresh;
      int p;
      point_sums_t want;
      rho_on = flag_density | flag_porosity | flag_saturation;
      mu_on = rho_on | flag_vs;
      en[A_LAMBDA] = mu_on | flag_vp;
      en[A_MU_A] = mu_on;
      en[A_MU_B] = mu_on;
      en[A_MU_C] = mu_on;
      en[A_RHO] = rho_on;
      fresh = (it.op == OP_START);
      p = int'(it.point);
      clipped = 1'b0;
      if (it.op == OP_ACCUMULATE || fresh) begin
        fxx = longint'($signed(it.fwd_sxx));
        fyy = longint'($signed(it.fwd_syy));
        fxy = longint'($signed(it.fwd_sxy));
        fvx = longint'($signed(it.fwd_vx));
        fvy = longint'($signed(it.fwd_vy));
        axx = longint'($signed(it.adj_sxx));
        ayy = longint'($signed(it.adj_syy));
        axy = longint'($signed(it.adj_sxy));
        avx = longint'($signed(it.adj_vx));
        avy = longint'($signed(it.adj_vy));
        delta[A_LAMBDA] = (fxx + fyy) * (axx + ayy);
        delta[A_MU_A] = fxx * axx + fyy * ayy;
        delta[A_MU_B] = fyy * axx + fxx * ayy;
        delta[A_MU_C] = fxy * axy;
        delta[A_RHO] = fvx * avx + fvy * avy;
        for (int k = 0; k < NUM_ACC; k++) begin
          sums[k] = en[k] ? clip_add(fresh ? 0 : point_acc[k][p], delta[k]) : 0;
          // a start rewrites every store of the point, disabled ones with zero
          if (en[k] || fresh) point_acc[k][p] = sums[k];
        end
      end else begin
        for (int k = 0; k < NUM_ACC; k++) sums[k] = en[k] ? point_acc[k][p] : 0;
      end
      want.lambda_sum = ACC_W'(sums[A_LAMBDA]);
      want.mu_a_sum = ACC_W'(sums[A_MU_A]);
      want.mu_b_sum = ACC_W'(sums[A_MU_B]);
      want.mu_c_sum = ACC_W'(sums[A_MU_C]);
      want.rho_sum = ACC_W'(sums[A_RHO]);
      want.saturated = clipped;
      expected_sums.push_back(want);
    endfunction

    function void check_result(point_sums_t got);
      point_sums_t want;
      if (expected_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: lam %h mua %h mub %h muc %h rho %h sat %b",
                   $time, got.lambda_sum, got.mu_a_sum, got.mu_b_sum, got.mu_c_sum,
                   got.rho_sum, got.saturated);
        return;
      end
      want = expected_sums.pop_front();
      if (want.lambda_sum !== got.lambda_sum || want.mu_a_sum !== got.mu_a_sum ||
          want.mu_b_sum !== got.mu_b_sum || want.mu_c_sum !== got.mu_c_sum ||
          want.rho_sum !== got.rho_sum || want.saturated !== got.saturated) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: expected lam %h mua %h mub %h muc %h rho %h sat %b", $time,
                   want.lambda_sum, want.mu_a_sum, want.mu_b_sum, want.mu_c_sum,
                   want.rho_sum, want.saturated);
          $display("%0t: actual   lam %h mua %h mub %h muc %h rho %h sat %b", $time,
                   got.lambda_sum, got.mu_a_sum, got.mu_b_sum, got.mu_c_sum,
                   got.rho_sum, got.saturated);
        end
      end
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  zlx_item_if #(.SAMPLE_BITS(SW)) item_ch ();
  zlx_result_if #(.ACC_BITS(ACC_W)) result_ch ();

  zero_lag_xcorr_accumulate_2d dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  xcorr_scoreboard sb;

  // Idle rates in percent of cycles, set per phase by the stimulus
  int src_idle_pct;
  int sink_idle_pct;

  // Long receiver hold-offs: the stimulus bumps hold_asked, the receiver serves it
  int hold_asked;
  int hold_given;
  int hold_left;

  // Points that a start has written; only these may be read or accumulated
  bit point_started [NPTS];
  logic [POINT_W-1:0] started_pts[$];
  logic [POINT_W-1:0] last_pt;

  int stall_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stall at random, or hold off for a whole stretch when asked
  initial begin
    result_ch.ready = 1'b0;
    hold_given = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_asked != hold_given) begin
        hold_given = hold_asked;
        hold_left = HOLD_CYCLES - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Monitor: sample every handshake and register write at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (item_ch.valid && item_ch.ready) sb.note_item(seen_item());
      if (result_ch.valid && result_ch.ready) sb.check_result(seen_result());
    end
  end

  // Watchdog: give up when no transaction or write moves for too long
  always @(posedge clk) begin
    if (rst || cfg_we || (item_ch.valid && item_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic grid_item_t seen_item();
    grid_item_t it;
    it.op = item_ch.op;
    it.point = item_ch.point;
    it.fwd_sxx = item_ch.fwd_sxx;
    it.fwd_syy = item_ch.fwd_syy;
    it.fwd_sxy = item_ch.fwd_sxy;
    it.fwd_vx = item_ch.fwd_vx;
    it.fwd_vy = item_ch.fwd_vy;
    it.adj_sxx = item_ch.adj_sxx;
    it.adj_syy = item_ch.adj_syy;
    it.adj_sxy = item_ch.adj_sxy;
    it.adj_vx = item_ch.adj_vx;
    it.adj_vy = item_ch.adj_vy;
    return it;
  endfunction

  function automatic point_sums_t seen_result();
    point_sums_t r;
    r.lambda_sum = result_ch.lambda_sum;
    r.mu_a_sum = result_ch.mu_a_sum;
    r.mu_b_sum = result_ch.mu_b_sum;
    r.mu_c_sum = result_ch.mu_c_sum;
    r.rho_sum = result_ch.rho_sum;
    r.saturated = result_ch.saturated;
    return r;
  endfunction

  // Favor the extremes of Q1.15 so products hit their largest magnitudes
  function automatic logic signed [SW-1:0] random_sample();
    case ($urandom_range(9))
      0: return S_MIN;
      1: return S_MAX;
      2: return '0;
      3: return '1;
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic grid_item_t uniform_item(logic [OP_W-1:0] op, logic [POINT_W-1:0] pt,
                                              logic signed [SW-1:0] f,
                                              logic signed [SW-1:0] a);
    grid_item_t it;
    it.op = op;
    it.point = pt;
    {it.fwd_sxx, it.fwd_syy, it.fwd_sxy, it.fwd_vx, it.fwd_vy} = {5{f}};
    {it.adj_sxx, it.adj_syy, it.adj_sxy, it.adj_vx, it.adj_vy} = {5{a}};
    return it;
  endfunction

  // Mostly accumulate runs on started points, often on the same point back to
  // back to exercise store forwarding; starts both open new points and restart
  // old ones.
  function automatic grid_item_t random_item();
    grid_item_t it;
    int roll;
    roll = $urandom_range(99);
    if (started_pts.size() == 0 || roll < 12) begin
      it.op = OP_START;
      case ($urandom_range(2))
        0: it.point = POINT_W'($urandom);
        1: it.point = (started_pts.size() != 0) ?
                      started_pts[$urandom_range(started_pts.size() - 1)] : POINT_W'($urandom);
        default: it.point = (started_pts.size() != 0) ? last_pt : POINT_W'($urandom);
      endcase
    end else begin
      if (roll < 67) it.op = OP_ACCUMULATE;
      else if (roll < 87) it.op = OP_READ;
      else if (roll < 93) it.op = OP_SPARE;
      else it.op = OP_START;
      it.point = ($urandom_range(99) < 45) ? last_pt :
                 started_pts[$urandom_range(started_pts.size() - 1)];
    end
    it.fwd_sxx = random_sample();
    it.fwd_syy = random_sample();
    it.fwd_sxy = random_sample();
    it.fwd_vx = random_sample();
    it.fwd_vy = random_sample();
    it.adj_sxx = random_sample();
    it.adj_syy = random_sample();
    it.adj_sxy = random_sample();
    it.adj_vx = random_sample();
    it.adj_vy = random_sample();
    return it;
  endfunction

  // Enter and leave at a falling edge; valid stays high when the next
  // transaction follows without a gap.
  task automatic send_item(grid_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    if (it.op == OP_START && !point_started[it.point]) begin
      point_started[it.point] = 1'b1;
      started_pts.push_back(it.point);
    end
    last_pt = it.point;
    item_ch.op <= it.op;
    item_ch.point <= it.point;
    item_ch.fwd_sxx <= it.fwd_sxx;
    item_ch.fwd_syy <= it.fwd_syy;
    item_ch.fwd_sxy <= it.fwd_sxy;
    item_ch.fwd_vx <= it.fwd_vx;
    item_ch.fwd_vy <= it.fwd_vy;
    item_ch.adj_sxx <= it.adj_sxx;
    item_ch.adj_syy <= it.adj_syy;
    item_ch.adj_sxy <= it.adj_sxy;
    item_ch.adj_vx <= it.adj_vx;
    item_ch.adj_vy <= it.adj_vy;
    item_ch.valid <= 1'b1;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and let every pending result come out before touching the flags
  task automatic wait_drain();
    item_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_flags(bit [4:0] flags);
    for (int k = 0; k < 5; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= FLAG_REGS[k];
      cfg_data <= flags[k];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    grid_item_t none;
    bit [4:0] flags;
    sb = new();
    none = '0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_ch.valid = 1'b0;
    {item_ch.op, item_ch.point, item_ch.fwd_sxx, item_ch.fwd_syy, item_ch.fwd_sxy,
     item_ch.fwd_vx, item_ch.fwd_vy, item_ch.adj_sxx, item_ch.adj_syy, item_ch.adj_sxy,
     item_ch.adj_vx, item_ch.adj_vy} = none;
    hold_asked = 0;
    last_pt = '0;
    src_idle_pct = 37;
    sink_idle_pct = 54;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes, every op, restart, back-to-back same point
    write_flags(5'b11111);
    send_item(uniform_item(OP_START, 12'd0, S_MAX, S_MAX));
    send_item(uniform_item(OP_ACCUMULATE, 12'd0, S_MIN, S_MIN));
    send_item(uniform_item(OP_ACCUMULATE, 12'd0, S_MIN, S_MAX));
    send_item(uniform_item(OP_READ, 12'd0, S_MAX, S_MIN));
    send_item(uniform_item(OP_START, 12'hFFF, S_MIN, S_MIN));
    send_item(uniform_item(OP_ACCUMULATE, 12'hFFF, S_MAX, S_MIN));
    send_item(uniform_item(OP_SPARE, 12'hFFF, S_MIN, S_MAX));
    send_item(uniform_item(OP_START, 12'hAAA, 16'h5555, 16'hAAAA));
    send_item(uniform_item(OP_START, 12'h555, 16'hAAAA, 16'h5555));
    send_item(uniform_item(OP_ACCUMULATE, 12'h555, '0, '0));
    send_item(uniform_item(OP_READ, 12'hAAA, '0, '0));
    send_item(uniform_item(OP_START, 12'h555, '1, '1));
    send_item(uniform_item(OP_READ, 12'h555, '0, '0));
    send_item(uniform_item(OP_ACCUMULATE, 12'd0, 16'sd1, '1));
    send_item(uniform_item(OP_ACCUMULATE, 12'hFFF, '1, 16'sd1));

    // Random phases: walk the flag groups; swap idle rates after three phases,
    // then run the last three with no idling
    for (int ph = 0; ph < 9; ph++) begin
      wait_drain();
      src_idle_pct = (ph < 3) ? 37 : (ph < 6) ? 54 : 0;
      sink_idle_pct = (ph < 3) ? 54 : (ph < 6) ? 37 : 0;
      flags = (ph == 8) ? 5'($urandom) : PHASE_FLAGS[ph];
      write_flags(flags);
      // hold the receiver off so the pipeline backs up into the input
      if (ph == 1 || ph == 6) hold_asked++;
      repeat (PHASE_ITEMS) send_item(random_item());
    end

    wait_drain();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

### zero_lag_xcorr_accumulate_2d.f
design/zlx_pkg.sv
design/zlx_item_if.sv
design/zlx_result_if.sv
design/zlx_prod.sv
design/zero_lag_xcorr_accumulate_2d.sv
design/zlx_checker.sv
verif/tb_top.sv
